// File: hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LRU buffer pool with pin counts.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int PIN_BITS_DEF = 8;

  localparam int PAGE_W     = 31;
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 3;
  localparam int CAP_W      = 5;
  localparam int SLOT_OUT_W = 4;
  localparam int PIN_OUT_W  = 8;
  localparam int CNT_OUT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 3'd0,
    ACT_GET   = 3'd1,
    ACT_PIN   = 3'd2,
    ACT_UNPIN = 3'd3,
    ACT_FLUSH = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT     = 3'd0,
    ST_LOADED  = 3'd1,
    ST_EVICT   = 3'd2,
    ST_REFUSED = 3'd3,
    ST_NOT_RES = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_DECIDE = 3'd2,
    S_SWEEP  = 3'd3,
    S_FINAL  = 3'd4
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lbp_slot_mem.sv
// ----------------------------------------------------------------------------
// lbp_slot_mem
// Slot entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hw/rtl/lbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: scans the slot memory, decides hit, fill, eviction or refusal,
// sweeps the recency ranks when a page is aged and commits the entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_ctrl #(
  parameter int SLOTS    = lbp_pkg::SLOTS_DEF,
  parameter int PIN_BITS = lbp_pkg::PIN_BITS_DEF,
  parameter int IDX_W    = $clog2(SLOTS),
  parameter int ENTRY_W  = lbp_pkg::PAGE_W + PIN_BITS + $clog2(SLOTS)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [lbp_pkg::CAP_W-1:0]          capacity,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [lbp_pkg::ACT_W-1:0]          in_action,
  input  wire logic [lbp_pkg::PAGE_W-1:0]         in_page_number,
  output logic                                    out_valid,
  output logic      [lbp_pkg::STAT_W-1:0]         out_status,
  output logic      [lbp_pkg::SLOT_OUT_W-1:0]     out_slot_index,
  output logic      [lbp_pkg::PIN_OUT_W-1:0]      out_pin_level,
  output logic                                    out_evicted_valid,
  output logic      [lbp_pkg::PAGE_W-1:0]         out_evicted_page,
  output logic      [lbp_pkg::CNT_OUT_W-1:0]      out_resident_count,
  output logic                                    out_room_left,
  output logic                                    mem_rd_en,
  output logic      [IDX_W-1:0]                   mem_rd_addr,
  input  wire logic [ENTRY_W-1:0]                 mem_rd_data,
  output logic                                    mem_wr_en,
  output logic      [IDX_W-1:0]                   mem_wr_addr,
  output logic      [ENTRY_W-1:0]                 mem_wr_data
);

  localparam int PAGE_W = lbp_pkg::PAGE_W;
  localparam int RANK_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int EFF_W  = (CNT_W > lbp_pkg::CAP_W) ? CNT_W : lbp_pkg::CAP_W;
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  lbp_pkg::state_t state_r, state_nxt;

  logic [lbp_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [PAGE_W-1:0]         page_r, page_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [SLOTS-1:0]          valid_r, valid_nxt;
  logic [CNT_W-1:0]          res_cnt_r, res_cnt_nxt;

  logic                      hit_r, hit_nxt;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [PIN_BITS-1:0]       hit_pins_r, hit_pins_nxt;
  logic [RANK_W-1:0]         hit_rank_r, hit_rank_nxt;
  logic                      free_r, free_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;
  logic                      vic_r, vic_nxt;
  logic [IDX_W-1:0]          vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0]         vic_rank_r, vic_rank_nxt;
  logic [PAGE_W-1:0]         vic_page_r, vic_page_nxt;

  logic [IDX_W-1:0]          tgt_r, tgt_nxt;
  logic [RANK_W-1:0]         old_rank_r, old_rank_nxt;
  logic                      all_r, all_nxt;
  logic [PIN_BITS-1:0]       fin_pins_r, fin_pins_nxt;
  logic [RANK_W-1:0]         fin_rank_r, fin_rank_nxt;
  logic                      do_wr_r, do_wr_nxt;
  logic                      set_valid_r, set_valid_nxt;
  logic                      slot_ok_r, slot_ok_nxt;
  lbp_pkg::status_t          status_r, status_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [lbp_pkg::STAT_W-1:0]          out_status_r, out_status_nxt;
  logic [lbp_pkg::SLOT_OUT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [lbp_pkg::PIN_OUT_W-1:0]       out_pin_r, out_pin_nxt;
  logic                                out_ev_r, out_ev_nxt;
  logic [PAGE_W-1:0]                   out_ev_page_r, out_ev_page_nxt;
  logic [lbp_pkg::CNT_OUT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                                out_room_r, out_room_nxt;

  logic [PAGE_W-1:0]   e_page;
  logic [PIN_BITS-1:0] e_pins;
  logic [RANK_W-1:0]   e_rank;
  logic                e_valid;
  logic [EFF_W-1:0]    eff_cap;
  logic                room;
  logic [CNT_W-1:0]    new_cnt;
  logic [31:0]         tgt_ext;
  logic [31:0]         pins_ext;
  logic [31:0]         cnt_ext;

  assign e_page  = mem_rd_data[ENTRY_W-1 -: PAGE_W];
  assign e_pins  = mem_rd_data[RANK_W +: PIN_BITS];
  assign e_rank  = mem_rd_data[RANK_W-1:0];
  assign e_valid = valid_r[rd_idx_r];

  always_comb begin
    if (capacity == '0) begin
      eff_cap = EFF_W'(1);
    end else if (EFF_W'(capacity) > EFF_W'(SLOTS)) begin
      eff_cap = EFF_W'(SLOTS);
    end else begin
      eff_cap = EFF_W'(capacity);
    end
  end

  assign room    = EFF_W'(res_cnt_r) < eff_cap;
  assign new_cnt = set_valid_r ? res_cnt_r + CNT_W'(1) : res_cnt_r;
  assign tgt_ext  = 32'(tgt_r);
  assign pins_ext = 32'(fin_pins_r);
  assign cnt_ext  = 32'(new_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbp_pkg::S_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      valid_r     <= valid_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    page_r        <= page_nxt;
    cnt_r         <= cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_pins_r    <= hit_pins_nxt;
    hit_rank_r    <= hit_rank_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    vic_r         <= vic_nxt;
    vic_idx_r     <= vic_idx_nxt;
    vic_rank_r    <= vic_rank_nxt;
    vic_page_r    <= vic_page_nxt;
    tgt_r         <= tgt_nxt;
    old_rank_r    <= old_rank_nxt;
    all_r         <= all_nxt;
    fin_pins_r    <= fin_pins_nxt;
    fin_rank_r    <= fin_rank_nxt;
    do_wr_r       <= do_wr_nxt;
    set_valid_r   <= set_valid_nxt;
    slot_ok_r     <= slot_ok_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_pin_r     <= out_pin_nxt;
    out_ev_r      <= out_ev_nxt;
    out_ev_page_r <= out_ev_page_nxt;
    out_cnt_r     <= out_cnt_nxt;
    out_room_r    <= out_room_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    page_nxt        = page_r;
    cnt_nxt         = cnt_r;
    valid_nxt       = valid_r;
    res_cnt_nxt     = res_cnt_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_pins_nxt    = hit_pins_r;
    hit_rank_nxt    = hit_rank_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    vic_nxt         = vic_r;
    vic_idx_nxt     = vic_idx_r;
    vic_rank_nxt    = vic_rank_r;
    vic_page_nxt    = vic_page_r;
    tgt_nxt         = tgt_r;
    old_rank_nxt    = old_rank_r;
    all_nxt         = all_r;
    fin_pins_nxt    = fin_pins_r;
    fin_rank_nxt    = fin_rank_r;
    do_wr_nxt       = do_wr_r;
    set_valid_nxt   = set_valid_r;
    slot_ok_nxt     = slot_ok_r;
    status_nxt      = status_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_pin_nxt     = out_pin_r;
    out_ev_nxt      = out_ev_r;
    out_ev_page_nxt = out_ev_page_r;
    out_cnt_nxt     = out_cnt_r;
    out_room_nxt    = out_room_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = cnt_r[IDX_W-1:0];
    mem_wr_en       = 1'b0;
    mem_wr_addr     = rd_idx_r;
    mem_wr_data     = {e_page, e_pins, e_rank + RANK_W'(1)};

    case (state_r)
      lbp_pkg::S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          page_nxt  = in_page_number;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          vic_nxt   = 1'b0;
          state_nxt = lbp_pkg::S_SCAN;
        end
      end
      lbp_pkg::S_SCAN: begin
        if (cnt_r < CNT_W'(SLOTS)) begin
          mem_rd_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = lbp_pkg::S_DECIDE;
        end
        if (rd_vld_r) begin
          if (!e_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (e_valid && e_page == page_r && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = rd_idx_r;
            hit_pins_nxt = e_pins;
            hit_rank_nxt = e_rank;
          end
          if (e_valid && e_pins == '0 && (!vic_r || e_rank > vic_rank_r)) begin
            vic_nxt      = 1'b1;
            vic_idx_nxt  = rd_idx_r;
            vic_rank_nxt = e_rank;
            vic_page_nxt = e_page;
          end
        end
      end
      lbp_pkg::S_DECIDE: begin
        do_wr_nxt     = 1'b0;
        set_valid_nxt = 1'b0;
        slot_ok_nxt   = 1'b0;
        all_nxt       = 1'b0;
        out_ev_nxt    = 1'b0;
        out_ev_page_nxt = '0;
        fin_pins_nxt  = '0;
        fin_rank_nxt  = '0;
        cnt_nxt       = '0;
        state_nxt     = lbp_pkg::S_FINAL;
        if (hit_r) begin
          status_nxt   = lbp_pkg::ST_HIT;
          slot_ok_nxt  = 1'b1;
          tgt_nxt      = hit_idx_r;
          fin_pins_nxt = hit_pins_r;
          fin_rank_nxt = hit_rank_r;
          case (act_r)
            lbp_pkg::ACT_GET: begin
              do_wr_nxt    = 1'b1;
              fin_rank_nxt = '0;
              old_rank_nxt = hit_rank_r;
              state_nxt    = lbp_pkg::S_SWEEP;
            end
            lbp_pkg::ACT_PIN: begin
              do_wr_nxt = 1'b1;
              if (hit_pins_r != PIN_MAX) begin
                fin_pins_nxt = hit_pins_r + PIN_BITS'(1);
              end
            end
            lbp_pkg::ACT_UNPIN: begin
              do_wr_nxt = 1'b1;
              if (hit_pins_r != '0) begin
                fin_pins_nxt = hit_pins_r - PIN_BITS'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (act_r inside {lbp_pkg::ACT_LOAD, lbp_pkg::ACT_GET, lbp_pkg::ACT_PIN}) begin
          fin_pins_nxt = (act_r == lbp_pkg::ACT_PIN) ? PIN_BITS'(1) : '0;
          if (room && free_r) begin
            status_nxt    = lbp_pkg::ST_LOADED;
            slot_ok_nxt   = 1'b1;
            do_wr_nxt     = 1'b1;
            set_valid_nxt = 1'b1;
            tgt_nxt       = free_idx_r;
            all_nxt       = 1'b1;
            state_nxt     = lbp_pkg::S_SWEEP;
          end else if (!room && vic_r) begin
            status_nxt      = lbp_pkg::ST_EVICT;
            slot_ok_nxt     = 1'b1;
            do_wr_nxt       = 1'b1;
            tgt_nxt         = vic_idx_r;
            old_rank_nxt    = vic_rank_r;
            out_ev_nxt      = 1'b1;
            out_ev_page_nxt = vic_page_r;
            state_nxt       = lbp_pkg::S_SWEEP;
          end else begin
            status_nxt = lbp_pkg::ST_REFUSED;
          end
        end else begin
          status_nxt = lbp_pkg::ST_NOT_RES;
        end
      end
      lbp_pkg::S_SWEEP: begin
        if (cnt_r < CNT_W'(SLOTS)) begin
          mem_rd_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = lbp_pkg::S_FINAL;
        end
        if (rd_vld_r && e_valid && rd_idx_r != tgt_r && (all_r || e_rank < old_rank_r)) begin
          mem_wr_en = 1'b1;
        end
      end
      lbp_pkg::S_FINAL: begin
        mem_wr_en      = do_wr_r;
        mem_wr_addr    = tgt_r;
        mem_wr_data    = {page_r, fin_pins_r, fin_rank_r};
        if (set_valid_r) begin
          valid_nxt[tgt_r] = 1'b1;
        end
        res_cnt_nxt    = new_cnt;
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_slot_nxt   = slot_ok_r ? tgt_ext[lbp_pkg::SLOT_OUT_W-1:0] : '0;
        out_pin_nxt    = slot_ok_r ? pins_ext[lbp_pkg::PIN_OUT_W-1:0] : '0;
        out_cnt_nxt    = cnt_ext[lbp_pkg::CNT_OUT_W-1:0];
        out_room_nxt   = EFF_W'(new_cnt) < eff_cap;
        state_nxt      = lbp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lbp_pkg::S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = mem_rd_en;
  assign rd_idx_nxt = cnt_r[IDX_W-1:0];

  assign busy               = (state_r != lbp_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_index     = out_slot_r;
  assign out_pin_level      = out_pin_r;
  assign out_evicted_valid  = out_ev_r;
  assign out_evicted_page   = out_ev_page_r;
  assign out_resident_count = out_cnt_r;
  assign out_room_left      = out_room_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CNT_W'(SLOTS) && EFF_W'(res_cnt_r) <= EFF_W'($countones(valid_r)))
    else $error("resident count exceeds valid slots");

  a_evict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lbp_pkg::ST_EVICT |-> out_evicted_valid)
    else $error("eviction without write-back flag");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lbp_pkg::ST_REFUSED || out_status == lbp_pkg::ST_NOT_RES)
    |-> out_slot_index == '0 && out_pin_level == '0 && !out_evicted_valid)
    else $error("non-resident result carries slot data");

endmodule

`default_nettype wire

// File: hw/rtl/lru_buffer_pool_with_pins.sv
// ----------------------------------------------------------------------------
// lru_buffer_pool_with_pins
// LRU buffer pool of page slots with pin counts, top level.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; busy then stays
// high until the request is finished. Every request walks all SLOTS entries
// of the slot memory once to look up the page; a hit on load, pin, unpin or
// a flush query ends after that walk. A get hit and every miss that loads a
// page walk the memory a second time to age the recency ranks. The result
// strobe out_valid rises in the cycle that busy falls and lasts one cycle;
// the receiver cannot stall it. Capacity may be written only while busy is
// low.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_buffer_pool_with_pins #(
  parameter int SLOTS    = lbp_pkg::SLOTS_DEF,
  parameter int PIN_BITS = lbp_pkg::PIN_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lbp_pkg::CAP_W-1:0]       cfg_wdata,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lbp_pkg::ACT_W-1:0]       in_action,
  input  wire logic [lbp_pkg::PAGE_W-1:0]      in_page_number,
  output logic                                 out_valid,
  output logic      [lbp_pkg::STAT_W-1:0]      out_status,
  output logic      [lbp_pkg::SLOT_OUT_W-1:0]  out_slot_index,
  output logic      [lbp_pkg::PIN_OUT_W-1:0]   out_pin_level,
  output logic                                 out_evicted_valid,
  output logic      [lbp_pkg::PAGE_W-1:0]      out_evicted_page,
  output logic      [lbp_pkg::CNT_OUT_W-1:0]   out_resident_count,
  output logic                                 out_room_left
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = lbp_pkg::PAGE_W + PIN_BITS + $clog2(SLOTS);

  logic [lbp_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic                      mem_rd_en;
  logic [IDX_W-1:0]          mem_rd_addr;
  logic [ENTRY_W-1:0]        mem_rd_data;
  logic                      mem_wr_en;
  logic [IDX_W-1:0]          mem_wr_addr;
  logic [ENTRY_W-1:0]        mem_wr_data;

  assign cap_nxt = cfg_we ? cfg_wdata : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lbp_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  lbp_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  lbp_ctrl #(
    .SLOTS    (SLOTS),
    .PIN_BITS (PIN_BITS),
    .IDX_W    (IDX_W),
    .ENTRY_W  (ENTRY_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .capacity           (cap_r),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_page_number     (in_page_number),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_pin_level      (out_pin_level),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_page   (out_evicted_page),
    .out_resident_count (out_resident_count),
    .out_room_left      (out_room_left),
    .mem_rd_en          (mem_rd_en),
    .mem_rd_addr        (mem_rd_addr),
    .mem_rd_data        (mem_rd_data),
    .mem_wr_en          (mem_wr_en),
    .mem_wr_addr        (mem_wr_addr),
    .mem_wr_data        (mem_wr_data)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the LRU buffer pool with pin counts.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver. A behavioral copy of the page
// slots predicts every result, and a clocked monitor checks each result field
// by field. Directed requests cover hits, misses, eviction, refusal, pin
// saturation and reserved action codes. Random phases run under several
// capacity settings, including 0 and 31.
// ----------------------------------------------------------------------------
module tb;

  localparam int NSLOT = lbp_pkg::SLOTS_DEF;

  typedef logic [lbp_pkg::ACT_W-1:0]     act_bits_t;
  typedef logic [lbp_pkg::PAGE_W-1:0]    page_t;
  typedef logic [lbp_pkg::PIN_OUT_W-1:0] pins_t;
  typedef logic [lbp_pkg::CAP_W-1:0]     cap_t;

  localparam pins_t PIN_MAX = pins_t'((1 << lbp_pkg::PIN_BITS_DEF) - 1);
  localparam act_bits_t ACT_RSVD5 = 3'd5;
  localparam act_bits_t ACT_RSVD6 = 3'd6;
  localparam act_bits_t ACT_RSVD7 = 3'd7;

  typedef struct {
    act_bits_t act;
    page_t     page;
  } pool_req_t;

  typedef struct packed {
    logic [lbp_pkg::STAT_W-1:0]     status;
    logic [lbp_pkg::SLOT_OUT_W-1:0] slot;
    logic [lbp_pkg::PIN_OUT_W-1:0]  pins;
    logic                           ev_valid;
    logic [lbp_pkg::PAGE_W-1:0]     ev_page;
    logic [lbp_pkg::CNT_OUT_W-1:0]  count;
    logic                           room;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cap_t cfg_wdata = '0;
  logic start = 1'b0;
  act_bits_t in_action = '0;
  page_t in_page_number = '0;
  logic busy;
  logic out_valid;
  logic [lbp_pkg::STAT_W-1:0] out_status;
  logic [lbp_pkg::SLOT_OUT_W-1:0] out_slot_index;
  logic [lbp_pkg::PIN_OUT_W-1:0] out_pin_level;
  logic out_evicted_valid;
  logic [lbp_pkg::PAGE_W-1:0] out_evicted_page;
  logic [lbp_pkg::CNT_OUT_W-1:0] out_resident_count;
  logic out_room_left;

  lru_buffer_pool_with_pins dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_page_number     (in_page_number),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_pin_level      (out_pin_level),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_page   (out_evicted_page),
    .out_resident_count (out_resident_count),
    .out_room_left      (out_room_left)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // slot state of the pool as the block should hold it
  logic  res_valid [NSLOT];
  page_t res_page  [NSLOT];
  pins_t res_pins  [NSLOT];
  int    res_rank  [NSLOT];
  cap_t  cap_setting = lbp_pkg::CAP_RESET;

  pool_req_t    req_backlog[$];
  pool_result_t awaited_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int status_seen [8];
  bit steady = 1'b0;

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      res_valid[i] = 1'b0;
      res_page[i] = '0;
      res_pins[i] = '0;
      res_rank[i] = 0;
    end
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
  end

  function automatic void make_newest(int s, int old_rank);
    for (int i = 0; i < NSLOT; i++)
      if (res_valid[i] && i != s && res_rank[i] < old_rank) res_rank[i] = res_rank[i] + 1;
    res_rank[s] = 0;
  endfunction

  function automatic pool_result_t pool_predict(act_bits_t act, page_t pg);
    pool_result_t r;
    int slot;
    int victim;
    int lim;
    int n;
    r = '0;
    r.status = lbp_pkg::ST_NOT_RES;
    slot = -1;
    victim = -1;
    n = 0;
    lim = (cap_setting == 0) ? 1 : ((cap_setting > NSLOT) ? NSLOT : int'(cap_setting));
    for (int i = 0; i < NSLOT; i++)
      if (slot < 0 && res_valid[i] && res_page[i] == pg) slot = i;
    if (slot >= 0) begin
      r.status = lbp_pkg::ST_HIT;
      if (act == lbp_pkg::ACT_GET) begin
        make_newest(slot, res_rank[slot]);
      end else if (act == lbp_pkg::ACT_PIN && res_pins[slot] != PIN_MAX) begin
        res_pins[slot] = res_pins[slot] + 1'b1;
      end else if (act == lbp_pkg::ACT_UNPIN && res_pins[slot] != 0) begin
        res_pins[slot] = res_pins[slot] - 1'b1;
      end
    end else if (act <= lbp_pkg::ACT_PIN) begin
      for (int i = 0; i < NSLOT; i++) if (res_valid[i]) n++;
      if (n < lim) begin
        for (int i = 0; i < NSLOT; i++) if (slot < 0 && !res_valid[i]) slot = i;
        make_newest(slot, NSLOT + 1);
        res_valid[slot] = 1'b1;
        r.status = lbp_pkg::ST_LOADED;
      end else begin
        for (int i = 0; i < NSLOT; i++)
          if (res_valid[i] && res_pins[i] == 0 &&
              (victim < 0 || res_rank[i] > res_rank[victim])) victim = i;
        if (victim < 0) begin
          r.status = lbp_pkg::ST_REFUSED;
        end else begin
          r.ev_valid = 1'b1;
          r.ev_page = res_page[victim];
          make_newest(victim, res_rank[victim]);
          slot = victim;
          r.status = lbp_pkg::ST_EVICT;
        end
      end
      if (slot >= 0) begin
        res_page[slot] = pg;
        res_pins[slot] = (act == lbp_pkg::ACT_PIN) ? pins_t'(1) : pins_t'(0);
      end
    end
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (res_valid[i]) n++;
    r.count = n[lbp_pkg::CNT_OUT_W-1:0];
    r.room = (n < lim);
    if (slot >= 0) begin
      r.slot = slot[lbp_pkg::SLOT_OUT_W-1:0];
      r.pins = res_pins[slot];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h", n_checked, field, got, want);
  endtask

  // driver: hold start until the transaction is taken, then advance
  always @(posedge clk) begin : drive
    bit taken;
    pool_req_t rq;
    if (rst_n) begin
      taken = start && !busy;
      if (taken) begin
        awaited_results.push_back(pool_predict(in_action, in_page_number));
        n_sent++;
      end
      if (taken || !start) begin
        if (req_backlog.size() > 0 && (steady || $urandom_range(99) >= 23)) begin
          rq = req_backlog.pop_front();
          start <= 1'b1;
          in_action <= rq.act;
          in_page_number <= rq.page;
        end else begin
          start <= 1'b0;
          in_action <= act_bits_t'($urandom);
          in_page_number <= page_t'($urandom);
        end
      end
    end
  end

  // monitor: check each result against the oldest prediction
  always @(posedge clk) begin : watch
    pool_result_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), '0);
      end else begin
        want = awaited_results.pop_front();
        status_seen[want.status]++;
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_slot_index !== want.slot)
          report_mismatch("slot_index", 32'(out_slot_index), 32'(want.slot));
        if (out_pin_level !== want.pins)
          report_mismatch("pin_level", 32'(out_pin_level), 32'(want.pins));
        if (out_evicted_valid !== want.ev_valid)
          report_mismatch("evicted_valid", 32'(out_evicted_valid), 32'(want.ev_valid));
        if (out_evicted_page !== want.ev_page)
          report_mismatch("evicted_page", 32'(out_evicted_page), 32'(want.ev_page));
        if (out_resident_count !== want.count)
          report_mismatch("resident_count", 32'(out_resident_count), 32'(want.count));
        if (out_room_left !== want.room)
          report_mismatch("room_left", 32'(out_room_left), 32'(want.room));
      end
      n_checked++;
    end
  end

  function automatic void queue_req(act_bits_t act, page_t pg);
    pool_req_t rq;
    rq.act = act;
    rq.page = pg;
    req_backlog.push_back(rq);
  endfunction

  task automatic drain;
    do @(negedge clk);
    while (req_backlog.size() != 0 || awaited_results.size() != 0 || start || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(cap_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = v;
  endtask

  task automatic random_phase(int count);
    page_t pool [20];
    int pool_n;
    int r;
    act_bits_t a;
    page_t pg;
    pool_n = $urandom_range(20, 3);
    for (int k = 0; k < 20; k++) pool[k] = page_t'($urandom);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 25) a = lbp_pkg::ACT_LOAD;
      else if (r < 50) a = lbp_pkg::ACT_GET;
      else if (r < 70) a = lbp_pkg::ACT_PIN;
      else if (r < 90) a = lbp_pkg::ACT_UNPIN;
      else if (r < 97) a = lbp_pkg::ACT_FLUSH;
      else a = act_bits_t'(ACT_RSVD5 + $urandom_range(2));
      pg = ($urandom_range(99) < 6) ? page_t'($urandom) : pool[$urandom_range(pool_n - 1)];
      queue_req(a, pg);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // hits, free-slot loads, unpin at zero, misses of unpin and flush
    queue_req(lbp_pkg::ACT_LOAD, 31'h0000_0000);
    queue_req(lbp_pkg::ACT_LOAD, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_GET, 31'h0000_0000);
    queue_req(lbp_pkg::ACT_LOAD, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_PIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_PIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h0000_0005);
    queue_req(lbp_pkg::ACT_FLUSH, 31'h0000_0000);
    queue_req(lbp_pkg::ACT_FLUSH, 31'h0000_3039);
    queue_req(ACT_RSVD5, 31'h0000_0000);
    queue_req(ACT_RSVD6, 31'h7FFF_FFFF);
    queue_req(ACT_RSVD7, 31'h0000_3039);
    queue_req(lbp_pkg::ACT_PIN, 31'h2AAA_AAAA);
    queue_req(lbp_pkg::ACT_GET, 31'h5555_5555);
    drain();

    // capacity 0 acts as 1: pin all residents, refuse, then evict below count
    write_capacity(5'd0);
    queue_req(lbp_pkg::ACT_PIN, 31'h0000_0000);
    queue_req(lbp_pkg::ACT_PIN, 31'h7FFF_FFFF);
    queue_req(lbp_pkg::ACT_PIN, 31'h5555_5555);
    queue_req(lbp_pkg::ACT_LOAD, 31'h0000_0009);
    queue_req(lbp_pkg::ACT_PIN, 31'h0000_0009);
    queue_req(lbp_pkg::ACT_GET, 31'h0000_0009);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h0000_0000);
    queue_req(lbp_pkg::ACT_LOAD, 31'h0000_0009);
    drain();

    // capacity above the slot count; run one page into pin saturation
    write_capacity(5'd31);
    for (int k = 0; k < 258; k++) queue_req(lbp_pkg::ACT_PIN, 31'h1234_5678);
    queue_req(lbp_pkg::ACT_UNPIN, 31'h1234_5678);
    queue_req(lbp_pkg::ACT_FLUSH, 31'h1234_5678);
    random_phase(28);

    write_capacity(5'd1);
    random_phase(28);
    write_capacity(5'd7);
    random_phase(28);
    write_capacity(5'd16);
    steady = 1'b1;
    random_phase(28);
    steady = 1'b0;
    write_capacity(cap_t'($urandom_range(15, 2)));
    random_phase(28);
    write_capacity(5'd0);
    random_phase(25);

    repeat (40) @(posedge clk);
    $display("%0d requests sent, %0d results checked over capacities 0 to 31",
             n_sent, n_checked);
    $display("hits %0d, free loads %0d, evictions %0d, refusals %0d, not resident %0d",
             status_seen[lbp_pkg::ST_HIT], status_seen[lbp_pkg::ST_LOADED],
             status_seen[lbp_pkg::ST_EVICT], status_seen[lbp_pkg::ST_REFUSED],
             status_seen[lbp_pkg::ST_NOT_RES]);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("[lru_buffer_pool_with_pins] OK");
    end else begin
      $display("[lru_buffer_pool_with_pins] ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("timeout after %0d requests", n_sent);
    $display("[lru_buffer_pool_with_pins] ERROR");
    $finish;
  end

endmodule
